>>> sv/xml_entity_unescaper_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the entity unescaper back stage
// ---------------------------------------------------------------------------
`ifndef XML_ENTITY_UNESCAPER_DEFINES_SVH
`define XML_ENTITY_UNESCAPER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define XUE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included
`define XUE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> sv/xue_pkg.sv
// ---------------------------------------------------------------------------
// xue_pkg
// Types, character codes and helpers of the entity unescaper.
// ---------------------------------------------------------------------------
package xue_pkg;

   // byte class assigned by the front end
   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_OPEN  = 2'd1,
      KIND_NAME  = 2'd2,
      KIND_CLOSE = 2'd3
   } kind_type;

   // classified byte passed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } op_type;

   // one decoded result
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } result_type;

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_QUOT  = 8'h22;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_G    = 8'h67;
   localparam logic [7:0] LOWER_L    = 8'h6C;
   localparam logic [7:0] LOWER_M    = 8'h6D;
   localparam logic [7:0] LOWER_O    = 8'h6F;
   localparam logic [7:0] LOWER_P    = 8'h70;
   localparam logic [7:0] LOWER_Q    = 8'h71;
   localparam logic [7:0] LOWER_S    = 8'h73;
   localparam logic [7:0] LOWER_T    = 8'h74;
   localparam logic [7:0] LOWER_U    = 8'h75;
   localparam logic [7:0] LOWER_X    = 8'h78;

   // map an ASCII hex digit to {valid, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

>>> sv/xue_queue.sv
// ---------------------------------------------------------------------------
// xue_queue
// Two-entry queue; push and pop may transfer in the same cycle.
// ---------------------------------------------------------------------------
module xue_queue #(
   parameter int WIDTH = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/xue_front.sv
// ---------------------------------------------------------------------------
// xue_front
// Accepts raw bytes, tracks entity mode and classifies each byte.
// ---------------------------------------------------------------------------
module xue_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   input  logic [7:0]      req_byte,
   input  logic            req_last,
   output logic            req_full,
   output logic            op_push,
   output xue_pkg::op_type op_item,
   input  logic            op_full
);

   logic in_entity_ff, in_entity_in;
   logic accept;

   assign req_full = op_full;
   assign op_push  = req_push;
   assign accept   = req_push && !op_full;

   // classify the byte and update the mode
   always_comb begin
      op_item.data = req_byte;
      op_item.last = req_last;
      in_entity_in = in_entity_ff;
      if (!in_entity_ff) begin
         if (req_byte == xue_pkg::CHAR_AMP) begin
            op_item.kind = xue_pkg::KIND_OPEN;
            in_entity_in = !req_last;
         end else begin
            op_item.kind = xue_pkg::KIND_PLAIN;
         end
      end else begin
         if (req_byte == xue_pkg::CHAR_SEMI) begin
            op_item.kind = xue_pkg::KIND_CLOSE;
            in_entity_in = 1'b0;
         end else begin
            op_item.kind = xue_pkg::KIND_NAME;
            in_entity_in = !req_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_entity_ff <= 1'b0;
      end else if (accept) begin
         in_entity_ff <= in_entity_in;
      end
   end

endmodule

>>> sv/xue_back.sv
// ---------------------------------------------------------------------------
// xue_back
// Collects entity names and decodes each finished entity to one byte.
// ---------------------------------------------------------------------------
`include "xml_entity_unescaper_defines.svh"

module xue_back #(
   parameter int NAME_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  xue_pkg::op_type     op_item,
   input  logic                op_empty,
   output logic                op_pop,
   output logic                res_push,
   output xue_pkg::result_type res_item,
   input  logic                res_full
);

   localparam int LW = $clog2(NAME_BYTES + 2);

   logic [7:0]    store_ff [NAME_BYTES];
   logic [7:0]    store_in [NAME_BYTES];
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    hex_ff, hex_in;
   logic          seen_ff, seen_in;
   logic          done_ff, done_in;
   logic [4:0]    nib;
   logic          fire, emit;
   logic          is_name, is_open;
   logic [7:0]    decoded;

   assign fire    = !op_empty && !res_full;
   assign op_pop  = fire;
   assign is_name = (op_item.kind == xue_pkg::KIND_NAME);
   assign is_open = (op_item.kind == xue_pkg::KIND_OPEN);
   assign nib     = xue_pkg::hex_nibble(op_item.data);

   // append a name byte, or clear on an ampersand
   always_comb begin
      len_in  = len_ff;
      hex_in  = hex_ff;
      seen_in = seen_ff;
      done_in = done_ff;
      for (int i = 0; i < NAME_BYTES; i++) begin
         store_in[i] = (is_name && len_ff == LW'(i)) ? op_item.data : store_ff[i];
      end
      if (is_open) begin
         len_in  = '0;
         hex_in  = 8'd0;
         seen_in = 1'b0;
         done_in = 1'b0;
      end else if (is_name) begin
         if (len_ff >= LW'(2) && !done_ff) begin
            if (nib[4]) begin
               hex_in  = {hex_ff[3:0], nib[3:0]};
               seen_in = 1'b1;
            end else begin
               done_in = 1'b1;
            end
         end
         if (len_ff <= LW'(NAME_BYTES)) begin
            len_in = len_ff + LW'(1);
         end
      end
   end

   // decode the name as it stands after this byte
   always_comb begin
      if (len_in == '0) begin
         decoded = xue_pkg::CHAR_NUL;
      end else if (len_in == LW'(3) && store_in[0] == xue_pkg::LOWER_A &&
                   store_in[1] == xue_pkg::LOWER_M && store_in[2] == xue_pkg::LOWER_P) begin
         decoded = xue_pkg::CHAR_AMP;
      end else if (len_in == LW'(4) && store_in[0] == xue_pkg::LOWER_A &&
                   store_in[1] == xue_pkg::LOWER_P && store_in[2] == xue_pkg::LOWER_O &&
                   store_in[3] == xue_pkg::LOWER_S) begin
         decoded = xue_pkg::CHAR_APOS;
      end else if (len_in == LW'(4) && store_in[0] == xue_pkg::LOWER_Q &&
                   store_in[1] == xue_pkg::LOWER_U && store_in[2] == xue_pkg::LOWER_O &&
                   store_in[3] == xue_pkg::LOWER_T) begin
         decoded = xue_pkg::CHAR_QUOT;
      end else if (len_in == LW'(2) && store_in[0] == xue_pkg::LOWER_G &&
                   store_in[1] == xue_pkg::LOWER_T) begin
         decoded = xue_pkg::CHAR_GT;
      end else if (len_in == LW'(2) && store_in[0] == xue_pkg::LOWER_L &&
                   store_in[1] == xue_pkg::LOWER_T) begin
         decoded = xue_pkg::CHAR_LT;
      end else if (len_in >= LW'(3) && store_in[0] == xue_pkg::CHAR_HASH &&
                   store_in[1] == xue_pkg::LOWER_X && seen_in) begin
         decoded = hex_in;
      end else begin
         decoded = store_in[0];
      end
   end

   // select the result for this byte class
   always_comb begin
      res_item.last = op_item.last;
      unique case (op_item.kind)
         xue_pkg::KIND_PLAIN: begin
            emit          = 1'b1;
            res_item.data = op_item.data;
         end
         xue_pkg::KIND_OPEN: begin
            emit          = op_item.last;
            res_item.data = xue_pkg::CHAR_NUL;
         end
         xue_pkg::KIND_NAME: begin
            emit          = op_item.last;
            res_item.data = decoded;
         end
         xue_pkg::KIND_CLOSE: begin
            emit          = 1'b1;
            res_item.data = decoded;
         end
         default: begin
            emit          = 1'b0;
            res_item.data = op_item.data;
         end
      endcase
   end

   assign res_push = fire && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         hex_ff  <= 8'd0;
         seen_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (fire) begin
         len_ff  <= len_in;
         hex_ff  <= hex_in;
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

   // hold name bytes; no reset needed
   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < NAME_BYTES; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   `XUE_ASSERT(a_open_clears, (fire && is_open) |=> (len_ff == '0 && !seen_ff), "stale name")
   `XUE_ASSERT(a_len_bound, len_ff <= LW'(NAME_BYTES + 1), "name length past saturation")
   `XUE_ASSERT(a_hex_needs_prefix, seen_ff |-> (len_ff >= LW'(3)), "hex digit seen before prefix")

endmodule

>>> sv/xml_entity_unescaper.sv
// ---------------------------------------------------------------------------
// xml_entity_unescaper
// Streaming decoder of XML entities in a string body.
// ---------------------------------------------------------------------------
// Takes one byte per cycle sustained while the consumer keeps popping, and
// gives at most one decoded byte per input byte. A front stage classifies
// each byte and tracks entity mode; a two-entry queue feeds the back stage,
// which collects entity names and decodes them; a second two-entry queue
// holds results for the consumer. A byte that produces a result is written
// to the op queue and then to the rsp queue, whose head drives the rsp ports;
// the back stage sets the rate: one queued byte per cycle unless rsp is full.
module xml_entity_unescaper #(
   parameter int NAME_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);

   xue_pkg::op_type     fe_item, be_item;
   xue_pkg::result_type res_item, rsp_item;
   logic                fe_push, op_full, op_empty, op_pop;
   logic                res_push, res_full;

   xue_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_byte (req_byte),
      .req_last (req_last),
      .req_full (req_full),
      .op_push  (fe_push),
      .op_item  (fe_item),
      .op_full  (op_full)
   );

   xue_queue #(.WIDTH($bits(xue_pkg::op_type))) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fe_push),
      .wr_data (fe_item),
      .full    (op_full),
      .pop     (op_pop),
      .rd_data (be_item),
      .empty   (op_empty)
   );

   xue_back #(.NAME_BYTES(NAME_BYTES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_item  (be_item),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .res_push (res_push),
      .res_item (res_item),
      .res_full (res_full)
   );

   xue_queue #(.WIDTH($bits(xue_pkg::result_type))) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_item),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp_item),
      .empty   (rsp_empty)
   );

   assign rsp_byte = rsp_item.data;
   assign rsp_last = rsp_item.last;

endmodule

>>> sim/xml_entity_unescaper_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xml_entity_unescaper_checker
// Watches both queue ports of the entity unescaper and checks every result.
// ---------------------------------------------------------------------------
// Each byte transfer on the req side runs through a local decoder that keeps
// its own entity state and queues the decoded byte it should cause. Each
// transfer on the rsp side is compared with the oldest queued byte. The
// count of failures and the number of results still owed go to the top.
module xml_entity_unescaper_checker #(
   parameter int NAME_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_byte,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);

   // local copy of the decoder state
   logic              entity_open;
   logic [7:0]        name_buf [NAME_BYTES];
   int                name_len;
   logic [7:0]        hex_acc;
   logic              hex_seen;
   logic              hex_frozen;

   // decoded bytes not yet seen on the rsp side
   xue_pkg::result_type decoded_q [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic logic name_matches(input string s);
      if (name_len != s.len() || s.len() > NAME_BYTES) begin
         return 1'b0;
      end
      for (int i = 0; i < s.len(); i++) begin
         if (name_buf[i] != s[i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // map a collected name to its byte
   function automatic logic [7:0] resolve_name();
      if (name_len == 0) return xue_pkg::CHAR_NUL;
      if (name_matches("amp")) return xue_pkg::CHAR_AMP;
      if (name_matches("apos")) return xue_pkg::CHAR_APOS;
      if (name_matches("quot")) return xue_pkg::CHAR_QUOT;
      if (name_matches("gt")) return xue_pkg::CHAR_GT;
      if (name_matches("lt")) return xue_pkg::CHAR_LT;
      if (name_len >= 3 && name_buf[0] == xue_pkg::CHAR_HASH &&
          name_buf[1] == xue_pkg::LOWER_X && hex_seen) begin
         return hex_acc;
      end
      return name_buf[0];
   endfunction

   // store a name byte and fold it into the hex value while digits last
   task automatic collect_name_byte(input logic [7:0] b);
      logic [4:0] digit;
      if (name_len < NAME_BYTES) begin
         name_buf[name_len] = b;
      end
      if (name_len >= 2 && !hex_frozen) begin
         if (b >= "0" && b <= "9") digit = {1'b1, 4'(b - "0")};
         else if (b >= "a" && b <= "f") digit = {1'b1, 4'(b - "a" + 8'd10)};
         else if (b >= "A" && b <= "F") digit = {1'b1, 4'(b - "A" + 8'd10)};
         else digit = 5'd0;
         if (digit[4]) begin
            hex_acc  = {hex_acc[3:0], digit[3:0]};
            hex_seen = 1'b1;
         end else begin
            hex_frozen = 1'b1;
         end
      end
      if (name_len <= NAME_BYTES) begin
         name_len++;
      end
   endtask

   // advance the decoder by one input byte and queue what it yields
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      xue_pkg::result_type r;
      if (!entity_open) begin
         if (b == xue_pkg::CHAR_AMP) begin
            entity_open = 1'b1;
            name_len    = 0;
            hex_acc     = 8'd0;
            hex_seen    = 1'b0;
            hex_frozen  = 1'b0;
            if (!fin) return;
            entity_open = 1'b0;
            r.data = xue_pkg::CHAR_NUL;
            r.last = 1'b1;
            decoded_q.push_back(r);
            return;
         end
         r.data = b;
         r.last = fin;
         decoded_q.push_back(r);
         return;
      end
      if (b != xue_pkg::CHAR_SEMI) begin
         collect_name_byte(b);
         if (!fin) return;
      end
      r.data = resolve_name();
      r.last = fin;
      decoded_q.push_back(r);
      entity_open = 1'b0;
   endtask

   // compare result transfers first, then predict from request transfers
   always @(posedge clock) begin
      xue_pkg::result_type want;
      if (reset) begin
         entity_open = 1'b0;
         name_len    = 0;
         hex_acc     = 8'd0;
         hex_seen    = 1'b0;
         hex_frozen  = 1'b0;
         for (int i = 0; i < NAME_BYTES; i++) name_buf[i] = 8'd0;
         decoded_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                         rsp_byte, rsp_last));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_byte !== want.data) begin
                  report_mismatch($sformatf("byte %02h, expected %02h", rsp_byte, want.data));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                            rsp_last, want.last, want.data));
               end
            end
         end
         if (req_push && !req_full) begin
            decode_byte(req_byte, req_last);
         end
      end
      pending = decoded_q.size();
   end

endmodule

>>> sim/xml_entity_unescaper_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xml_entity_unescaper_tb
// Stimulus and verdict for the streaming XML entity unescaper.
// ---------------------------------------------------------------------------
// Feeds string bodies byte by byte: a few hand-picked strings first, then
// random strings built from plain runs, named and numeric entities, unknown,
// empty and overlong names, and entities left open at the final byte. The
// checker beside the block predicts and compares; this module only drives
// the ports, varies the stall pattern on both sides and reports the result.
module xml_entity_unescaper_tb;

   localparam int NAME_BYTES = 8;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic [7:0] req_byte;
   logic       req_last;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_byte;
   logic       rsp_last;

   int         fail_count;
   int         pending;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         hold_requests;
   int         sent_count;
   int         string_count;
   logic [7:0] text_q [$];

   string      entity_names [5] = '{"amp", "apos", "quot", "gt", "lt"};
   string      near_misses [8]  = '{"#X41", "#", "x41", "#xg1", "#x", "ampx", "am", "LT"};
   string      hex_chars        = "0123456789abcdefABCDEF";

   xml_entity_unescaper #(
      .NAME_BYTES(NAME_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_byte (req_byte),
      .req_last (req_last),
      .req_full (req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_byte (rsp_byte),
      .rsp_last (rsp_last)
   );

   xml_entity_unescaper_checker #(
      .NAME_BYTES(NAME_BYTES)
   ) checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // stop a hung run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random pops, or a long hold-off when the sender asks for one
   initial begin
      int hold_seen;
      int hold_left;
      rsp_pop   = 1'b0;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 64;
         end
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      // keep plain runs in text mode; a semicolon here still passes through
      if (b == xue_pkg::CHAR_AMP) b = xue_pkg::CHAR_SEMI;
      return b;
   endfunction

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      // never close the name early; an ampersand is an ordinary name byte
      if (b == xue_pkg::CHAR_SEMI) b = xue_pkg::CHAR_AMP;
      return b;
   endfunction

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // append the body of one entity name, without the closing semicolon
   task automatic add_name();
      int n;
      case ($urandom_range(7))
         0, 7: push_string(entity_names[$urandom_range(4)]);
         1: begin
            text_q.push_back(xue_pkg::CHAR_HASH);
            text_q.push_back(xue_pkg::LOWER_X);
            n = $urandom_range(8);
            repeat (n) text_q.push_back(hex_chars[$urandom_range(21)]);
            // trailing non-hex byte freezes the value; later digits are ignored
            if ($urandom_range(2) == 0) begin
               text_q.push_back(xue_pkg::LOWER_Q);
               repeat ($urandom_range(2)) text_q.push_back(hex_chars[$urandom_range(21)]);
            end
         end
         2: push_string(near_misses[$urandom_range(7)]);
         3: repeat ($urandom_range(14, NAME_BYTES + 1)) text_q.push_back(name_byte());
         5: repeat ($urandom_range(NAME_BYTES, 1)) text_q.push_back(name_byte());
         6: begin
            push_string(entity_names[$urandom_range(4)]);
            text_q.push_back(name_byte());
         end
         default: ;
      endcase
   endtask

   // build one random string body in text_q
   task automatic make_text();
      text_q.delete();
      if ($urandom_range(9) == 0) begin
         // noise: raw bytes with many ampersands and semicolons
         repeat ($urandom_range(16, 1)) begin
            case ($urandom_range(3))
               0: text_q.push_back(xue_pkg::CHAR_AMP);
               1: text_q.push_back(xue_pkg::CHAR_SEMI);
               default: text_q.push_back(8'($urandom_range(255)));
            endcase
         end
         return;
      end
      repeat ($urandom_range(8, 1)) begin
         if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(4, 1)) text_q.push_back(plain_byte());
         end else begin
            text_q.push_back(xue_pkg::CHAR_AMP);
            add_name();
            text_q.push_back(xue_pkg::CHAR_SEMI);
         end
      end
      // sometimes end with an entity still open
      case ($urandom_range(7))
         0: text_q.push_back(xue_pkg::CHAR_AMP);
         1: begin
            text_q.push_back(xue_pkg::CHAR_AMP);
            add_name();
         end
         default: ;
      endcase
   endtask

   // offer one byte with random gaps and hold it until the transfer
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_byte <= b;
      req_last <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
      string_count++;
   endtask

   // stop offering until every decoded byte has come out, then let it settle
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      int  phase;
      bit  burst_done;
      req_push      = 1'b0;
      req_byte      = 8'd0;
      req_last      = 1'b0;
      reset         = 1'b1;
      send_idle_pct = 23;
      recv_idle_pct = 49;
      hold_requests = 0;
      sent_count    = 0;
      string_count  = 0;
      burst_done    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero byte as a whole string
      text_q = {xue_pkg::CHAR_NUL};
      send_text();
      // top byte, semicolon in text, gt, then an empty name at the end
      text_q = {8'hFF, xue_pkg::CHAR_SEMI, xue_pkg::CHAR_AMP, xue_pkg::LOWER_G,
                xue_pkg::LOWER_T, xue_pkg::CHAR_SEMI, xue_pkg::CHAR_AMP,
                xue_pkg::CHAR_SEMI};
      send_text();
      // mixed-case hex value, then a lone ampersand as final byte
      text_q = {xue_pkg::CHAR_AMP, xue_pkg::CHAR_HASH, xue_pkg::LOWER_X, 8'h41, 8'h66,
                xue_pkg::CHAR_SEMI, xue_pkg::CHAR_AMP};
      send_text();
      // ampersand and zero byte inside a name left open at the final byte
      text_q = {xue_pkg::CHAR_AMP, xue_pkg::LOWER_A, xue_pkg::CHAR_AMP, xue_pkg::CHAR_NUL};
      send_text();
      // hex prefix with no digit, open at the final byte
      text_q = {xue_pkg::CHAR_AMP, xue_pkg::CHAR_HASH, xue_pkg::LOWER_X};
      send_text();

      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 49;
            recv_idle_pct <= 23;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         while (sent_count < (phase + 1) * 467) begin
            if (phase == 0 && !burst_done && sent_count >= 200) begin
               // hold off the receiver and keep pushing until the input stalls
               burst_done = 1'b1;
               hold_requests <= hold_requests + 1;
               send_idle_pct = 0;
               text_q.delete();
               repeat (40) text_q.push_back(plain_byte());
               send_text();
               send_idle_pct = 23;
            end
            make_text();
            send_text();
         end
         wait_for_results();
      end

      repeat (20) @(negedge clock);
      $display("covered %0d bytes in %0d strings: named, hex, unknown, empty, long and open",
               sent_count, string_count);
      $display("entities under three stall patterns plus a full-queue hold-off");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/xue_pkg.sv
sv/xue_queue.sv
sv/xue_front.sv
sv/xue_back.sv
sv/xml_entity_unescaper.sv
sim/xml_entity_unescaper_checker.sv
sim/xml_entity_unescaper_tb.sv
